// ----- rtl/generational_slot_handle_table_macros.svh -----
// Assertion macros shared by the checker of the slot handle table.
`ifndef GENERATIONAL_SLOT_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_SLOT_HANDLE_TABLE_MACROS_SVH

// A beat that is offered and held back must stay offered and unchanged.
`define GSHT_ASSERT_HOLD(name, clk, rst_n, vld, stl, data) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && (stl)) |=> ((vld) && $stable(data))) \
    else $error("held beat changed or dropped");

// A condition on the same edge implies a rule on the same edge.
`define GSHT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("result beat breaks a table rule");

`endif

// ----- rtl/gsht_pkg.sv -----
// Package with the types, codes and helpers of the slot handle table.
`default_nettype none

package gsht_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_STALE     = 3'd4;

  localparam logic [31:0] GEN_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] GEN_FIRST = 32'd1;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic        entry_kind;
    logic        entry_valid;
    logic [15:0] handle_index;
    logic [31:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_index;
    logic [31:0] result_generation;
    logic [6:0]  occupied_count;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_REPLY,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  status;
    logic [15:0] idx;
    logic [31:0] gen;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_SCAN,
    BK_ADD_READ,
    BK_CHECK,
    BK_SWEEP,
    BK_DONE
  } bk_state_t;

  function automatic logic [31:0] gen_bump(input logic [31:0] g);
    return (g == GEN_MAX) ? GEN_FIRST : g + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gsht_front.sv -----
// Front end: takes request beats and sorts them into queue commands.
`default_nettype none

module gsht_front #(
  parameter int SLOTS = 64
) (
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsht_pkg::in_item_t in_data,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              q_push,
  output gsht_pkg::cmd_t    q_cmd
);
  import gsht_pkg::*;

  logic out_of_range;

  // Hold requests back while in reset, while the queue is full or while the tables are being set up.
  assign in_stall = q_full || init_busy || !rst_n;
  assign q_push   = in_valid && !in_stall;

  assign out_of_range = (in_data.handle_generation == 32'd0) ||
                        (in_data.handle_index >= 16'(SLOTS));

  always_comb begin
    q_cmd.op     = OP_REPLY;
    q_cmd.status = ST_NOT_FOUND;
    q_cmd.idx    = 16'd0;
    q_cmd.gen    = 32'd0;
    case (in_data.func)
      FUNC_ADD: begin
        if (in_data.entry_valid) begin
          q_cmd.op = OP_ADD;
        end else begin
          q_cmd.status = ST_INVALID;
        end
      end
      FUNC_REMOVE: begin
        q_cmd.idx = in_data.handle_index;
        q_cmd.gen = in_data.handle_generation;
        if (!out_of_range) begin
          q_cmd.op = OP_REMOVE;
        end
      end
      FUNC_CLEAR: begin
        q_cmd.op     = OP_CLEAR;
        q_cmd.status = ST_ACCEPTED;
      end
      default: begin
        // The unused code answers "not found" and touches nothing.
        q_cmd.op = OP_REPLY;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gsht_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module gsht_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gsht_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gsht_pkg::cmd_t head_cmd
);
  import gsht_pkg::*;

  cmd_t            entry_r [QDEPTH];
  logic [QPW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gsht_back.sv -----
// Back end: slot tables, free-slot scan, generation updates and result register.
`default_nettype none

module gsht_back #(
  parameter int SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gsht_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output gsht_pkg::out_item_t out_data
);
  import gsht_pkg::*;

  localparam int CHUNK      = (SLOTS >= 32) ? 32 : (1 << $clog2(SLOTS));
  localparam int CB         = $clog2(CHUNK);
  localparam int NCHUNK     = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int WW         = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SW         = $clog2(SLOTS);
  localparam int CW         = $clog2(SLOTS + 1);
  localparam int LAST_VALID = SLOTS - (NCHUNK - 1) * CHUNK;
  localparam logic [CHUNK-1:0] LAST_MASK =
    CHUNK'(({{CHUNK{1'b0}}, 1'b1} << LAST_VALID) - 1'b1);
  localparam logic [WW-1:0] LAST_WORD = WW'(NCHUNK - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // Generation per slot, and occupancy packed CHUNK slots to a word.
  logic [31:0]      gen_mem  [SLOTS];
  logic [CHUNK-1:0] busy_mem [NCHUNK];

  logic             gen_re, gen_we;
  logic [SW-1:0]    gen_ra, gen_wa;
  logic [31:0]      gen_wd, gen_q;
  logic             busy_re, busy_we;
  logic [WW-1:0]    busy_ra, busy_wa;
  logic [CHUNK-1:0] busy_wd, busy_q;

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [WW-1:0]    word_r, word_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SW-1:0]    sweep_r, sweep_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic [15:0]      res_idx_r, res_idx_nxt;
  logic [31:0]      res_gen_r, res_gen_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CHUNK-1:0] free_bits;
  logic [CB-1:0]    free_off;
  logic             found;
  logic             last_word;
  logic [SW-1:0]    new_slot;
  logic [SW-1:0]    rm_slot;
  logic [WW-1:0]    rm_word;
  logic [CB-1:0]    rm_off;
  logic             rm_busy;
  logic             rm_match;
  logic             sweep_last;
  logic             sweep_word_start;
  logic [WW-1:0]    sweep_word;
  logic             out_free;

  assign last_word = (word_r == LAST_WORD);
  assign free_bits = ~busy_q & (last_word ? LAST_MASK : {CHUNK{1'b1}});
  assign found     = |free_bits;

  always_comb begin
    free_off = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_off = CB'(i);
      end
    end
  end

  assign new_slot = SW'({word_r, free_off});

  assign rm_slot  = cmd_r.idx[SW-1:0];
  assign rm_word  = WW'(cmd_r.idx >> CB);
  assign rm_off   = cmd_r.idx[CB-1:0];
  assign rm_busy  = busy_q[rm_off];
  assign rm_match = (gen_q == cmd_r.gen);

  assign sweep_last       = (sweep_r == LAST_SLOT);
  assign sweep_word_start = (sweep_r[CB-1:0] == '0);
  assign sweep_word       = WW'(sweep_r >> CB);

  assign out_free = !out_valid_r || !out_stall;

  assign init_busy = (state_r == BK_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (sweep_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_ADD:    state_nxt = BK_SCAN;
            OP_REMOVE: state_nxt = BK_CHECK;
            OP_CLEAR:  state_nxt = BK_SWEEP;
            default:   state_nxt = BK_DONE;
          endcase
        end
      end
      BK_SCAN: begin
        if (found) begin
          state_nxt = BK_ADD_READ;
        end else if (last_word) begin
          state_nxt = BK_DONE;
        end
      end
      BK_ADD_READ: state_nxt = BK_DONE;
      BK_CHECK:    state_nxt = BK_DONE;
      BK_SWEEP: begin
        if (sweep_last) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    gen_re         = 1'b0;
    gen_ra         = '0;
    gen_we         = 1'b0;
    gen_wa         = '0;
    gen_wd         = gen_bump(gen_q);
    busy_re        = 1'b0;
    busy_ra        = '0;
    busy_we        = 1'b0;
    busy_wa        = '0;
    busy_wd        = '0;
    cmd_nxt        = cmd_r;
    word_nxt       = word_r;
    slot_nxt       = slot_r;
    sweep_nxt      = sweep_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_gen_nxt    = res_gen_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    case (state_r)
      BK_INIT: begin
        gen_we = 1'b1;
        gen_wa = sweep_r;
        gen_wd = GEN_FIRST;
        if (sweep_word_start) begin
          busy_we = 1'b1;
          busy_wa = sweep_word;
        end
        sweep_nxt = sweep_last ? '0 : sweep_r + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            OP_ADD: begin
              busy_re  = 1'b1;
              word_nxt = '0;
            end
            OP_REMOVE: begin
              gen_re  = 1'b1;
              gen_ra  = q_cmd.idx[SW-1:0];
              busy_re = 1'b1;
              busy_ra = WW'(q_cmd.idx >> CB);
            end
            OP_CLEAR: begin
              gen_re    = 1'b1;
              sweep_nxt = '0;
            end
            default: begin
              res_status_nxt = q_cmd.status;
              res_idx_nxt    = q_cmd.idx;
              res_gen_nxt    = q_cmd.gen;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (found) begin
          busy_we   = 1'b1;
          busy_wa   = word_r;
          busy_wd   = busy_q | (CHUNK'(1) << free_off);
          gen_re    = 1'b1;
          gen_ra    = new_slot;
          slot_nxt  = new_slot;
          count_nxt = count_r + 1'b1;
        end else if (last_word) begin
          res_status_nxt = ST_FULL;
          res_idx_nxt    = 16'd0;
          res_gen_nxt    = 32'd0;
        end else begin
          busy_re  = 1'b1;
          busy_ra  = word_r + 1'b1;
          word_nxt = word_r + 1'b1;
        end
      end
      BK_ADD_READ: begin
        res_status_nxt = ST_ACCEPTED;
        res_idx_nxt    = 16'(slot_r);
        res_gen_nxt    = gen_q;
      end
      BK_CHECK: begin
        res_idx_nxt = cmd_r.idx;
        res_gen_nxt = cmd_r.gen;
        if (!rm_busy) begin
          res_status_nxt = ST_NOT_FOUND;
        end else if (!rm_match) begin
          res_status_nxt = ST_STALE;
        end else begin
          res_status_nxt = ST_ACCEPTED;
          gen_we         = 1'b1;
          gen_wa         = rm_slot;
          busy_we        = 1'b1;
          busy_wa        = rm_word;
          busy_wd        = busy_q & ~(CHUNK'(1) << rm_off);
          count_nxt      = count_r - 1'b1;
        end
      end
      BK_SWEEP: begin
        gen_we = 1'b1;
        gen_wa = sweep_r;
        if (sweep_word_start) begin
          busy_we = 1'b1;
          busy_wa = sweep_word;
        end
        if (sweep_last) begin
          sweep_nxt      = '0;
          count_nxt      = '0;
          res_status_nxt = ST_ACCEPTED;
          res_idx_nxt    = 16'd0;
          res_gen_nxt    = 32'd0;
        end else begin
          gen_re    = 1'b1;
          gen_ra    = sweep_r + 1'b1;
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.status             = res_status_r;
          out_data_nxt.result_index       = res_idx_r;
          out_data_nxt.result_generation  = res_gen_r;
          out_data_nxt.occupied_count     = 7'(count_r);
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    word_r       <= word_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_gen_r    <= res_gen_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_q <= gen_mem[gen_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    if (busy_re) begin
      busy_q <= busy_mem[busy_ra];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/generational_slot_handle_table.sv -----
// Top level of the generational slot handle table.
//
//   Port group  Dir  Beat type             Flow control
//   in_         in   gsht_pkg::in_item_t   in_valid, in_stall
//   out_        out  gsht_pkg::out_item_t  out_valid, out_stall
//
// In the back end, a request answered straight away (invalid add, bad handle,
// unused code) goes to the result register without touching the tables; a
// remove reads the slot's generation and occupancy word; an add reads the
// occupancy words, up to 32 slots to a word, until one holds a free slot or
// the last word is read; and clear walks the generation memory one slot a
// cycle.
// After reset the tables are set up slot by slot; in_stall is high then.
// The queue holds up to two requests while the back end works, and a
// finished result waits in the output register while out_stall is high.
`default_nettype none

module generational_slot_handle_table #(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gsht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gsht_pkg::out_item_t out_data
);
  import gsht_pkg::*;

  // Commands travel from the front end to the back end through the queue.
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic head_valid;
  logic init_busy;

  // The front end sorts each request: bad handles, invalid adds and unused codes
  // are answered without touching the tables, the rest become table commands.
  gsht_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .init_busy(init_busy),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  gsht_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // The back end owns the generation and occupancy memories and the
  // occupied-slot count, and drives the result register.
  gsht_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (head_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/gsht_checker.sv -----
// Port-level checker for the slot handle table and its bind statement.
`default_nettype none
`include "generational_slot_handle_table_macros.svh"

module gsht_checker #(
  parameter int SLOTS = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input gsht_pkg::out_item_t out_data
);
  import gsht_pkg::*;

  `GSHT_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_stall, out_data)
  `GSHT_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (out_data.status == ST_FULL), out_data.occupied_count == 7'(SLOTS))
  `GSHT_ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && (out_data.status == ST_INVALID), (out_data.result_index == 16'd0) && (out_data.result_generation == 32'd0))
  `GSHT_ASSERT_IMPL(a_accept_gen, clk, rst_n, out_valid && (out_data.status == ST_ACCEPTED) && (out_data.result_index != 16'd0), out_data.result_generation != 32'd0)

endmodule

bind generational_slot_handle_table gsht_checker #(
  .SLOTS(SLOTS)
) u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
